[rtl/session_member_table_with_aging_core_assert.svh]
// assertion macros for the session member table core
// used by the engine; compiled out when SYNTHESIS is defined
`ifndef SESSION_MEMBER_TABLE_WITH_AGING_CORE_ASSERT_SVH
`define SESSION_MEMBER_TABLE_WITH_AGING_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SMTA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define SMTA_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SMTA_ASSERT(label, clk, rst, prop, msg)
`define SMTA_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[rtl/smta_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the session member table core
// no dependencies
package smta_pkg;

  typedef enum logic [1:0] {
    STATUS_KNOWN = 2'd0,
    STATUS_ADDED = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam logic [7:0] CFG_ROOM_SIZE = 8'd0;
  localparam logic [7:0] CFG_EXPIRY    = 8'd1;

  localparam logic [4:0]  ROOM_SIZE_RESET = 5'd16;
  localparam logic [31:0] EXPIRY_RESET    = 32'd1000000;

  localparam logic [63:0] LATENCY_LIMIT_US = 64'd200000;
  localparam logic [63:0] WINDOW_OPEN_US   = 64'd10000;
  localparam logic [63:0] WINDOW_PERIOD_US = 64'd100000;

  typedef struct packed {
    status_t     status;
    logic [3:0]  position;
    logic        latency_valid;
    logic [17:0] latency_us;
    logic [63:0] stamp_us;
    logic [4:0]  member_count;
  } res_t;

endpackage

[rtl/smta_engine.sv]
`timescale 1ns / 1ps
// member memories and the per-word sequencer: aging pass, lookup, update, ping sweep
// depends on smta_pkg and session_member_table_with_aging_core_assert.svh
`include "session_member_table_with_aging_core_assert.svh"

module smta_engine #(
  parameter int MAX_MEMBERS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      client_id,
  input  logic [63:0]      now_us,
  input  logic [63:0]      echo_us,
  input  logic [4:0]       room_size,
  input  logic [31:0]      expiry_us,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_take,
  output smta_pkg::res_t   res
);

  localparam int IW = $clog2(MAX_MEMBERS);
  localparam int CW = $clog2(MAX_MEMBERS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_AGE    = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_SWEEP  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // entry memory {id, seen} and pending-flag memory
  logic [95:0] mem_a [MAX_MEMBERS];
  logic        mem_b [MAX_MEMBERS];

  state_t      state;
  logic [CW-1:0] total;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] keep;
  logic [CW-1:0] sw_cnt;
  logic        dv;
  logic        found;
  logic [IW-1:0] pos;
  logic        pend_hit;
  logic        window_open;
  logic [63:0] window_start;

  logic [31:0] cur_id;
  logic [63:0] cur_now;
  logic [63:0] cur_echo;

  logic [95:0] ra_q;
  logic        rb_q;

  logic        rd_en;
  logic [IW-1:0] rd_addr;
  logic        wa_en;
  logic        wb_en;
  logic [IW-1:0] wr_addr;
  logic [95:0] wa_data;
  logic        wb_data;

  // aging pass
  logic [31:0] age_id;
  logic [63:0] age_diff;
  logic        survive;
  logic        match;

  // update step
  logic [63:0] lat_diff;
  logic        lat_ok;
  logic        clear_pend;
  logic [63:0] win_d;
  logic        open_now;
  logic        close_now;
  logic        restart;
  logic        win_next;
  logic        rise;
  logic        can_add;
  logic [CW-1:0] cnt_after;
  logic [63:0] pos_ext;
  logic [63:0] cnt_ext;

  always_ff @(posedge clk) begin
    if (wa_en) begin
      mem_a[wr_addr] <= wa_data;
    end
    if (wb_en) begin
      mem_b[wr_addr] <= wb_data;
    end
    if (rd_en) begin
      ra_q <= mem_a[rd_addr];
      rb_q <= mem_b[rd_addr];
    end
  end

  assign age_id   = ra_q[95:64];
  assign age_diff = cur_now - ra_q[63:0];
  assign survive  = dv && !(age_diff > {32'd0, expiry_us});
  assign match    = survive && (age_id == cur_id) && !found;

  assign lat_diff   = cur_now - cur_echo;
  assign lat_ok     = lat_diff < smta_pkg::LATENCY_LIMIT_US;
  assign clear_pend = pend_hit && (cur_echo != 64'd0);
  assign win_d      = cur_now - window_start;
  assign open_now   = win_d < smta_pkg::WINDOW_OPEN_US;
  assign close_now  = win_d > smta_pkg::WINDOW_OPEN_US;
  assign restart    = win_d > smta_pkg::WINDOW_PERIOD_US;
  assign win_next   = open_now ? 1'b1 : (close_now ? 1'b0 : window_open);
  assign rise       = open_now && !window_open;
  assign can_add    = (32'(total) < 32'(room_size)) && (32'(total) < MAX_MEMBERS);
  assign cnt_after  = (!found && can_add) ? total + CW'(1) : total;
  assign pos_ext    = 64'(pos);
  assign cnt_ext    = 64'(cnt_after);

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_cnt[IW-1:0];
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    wr_addr = keep[IW-1:0];
    wa_data = ra_q;
    wb_data = rb_q;
    unique case (state)
      ST_AGE: begin
        rd_en = rd_cnt < total;
        wa_en = survive;
        wb_en = survive;
      end
      ST_UPDATE: begin
        wa_data = {cur_id, cur_now};
        wb_data = 1'b0;
        if (found) begin
          wr_addr = pos;
          wa_en   = 1'b1;
          wb_en   = clear_pend;
        end else begin
          wr_addr = total[IW-1:0];
          wa_en   = can_add;
          wb_en   = can_add;
        end
      end
      ST_SWEEP: begin
        wr_addr = sw_cnt[IW-1:0];
        wb_data = 1'b1;
        wb_en   = sw_cnt < total;
      end
      ST_IDLE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // latched word fields and result payload
  always_ff @(posedge clk) begin
    if (idle && start) begin
      cur_id   <= client_id;
      cur_now  <= now_us;
      cur_echo <= echo_us;
    end
    if (state == ST_AGE && match) begin
      pos      <= keep[IW-1:0];
      pend_hit <= rb_q;
    end
    if (state == ST_UPDATE) begin
      res.member_count <= cnt_ext[4:0];
      if (found) begin
        res.status        <= smta_pkg::STATUS_KNOWN;
        res.position      <= pos_ext[3:0];
        res.latency_valid <= clear_pend && lat_ok;
        res.latency_us    <= (clear_pend && lat_ok) ? lat_diff[17:0] : 18'd0;
        res.stamp_us      <= win_next ? cur_now : 64'd0;
      end else begin
        res.status        <= can_add ? smta_pkg::STATUS_ADDED : smta_pkg::STATUS_FULL;
        res.position      <= 4'd0;
        res.latency_valid <= 1'b0;
        res.latency_us    <= 18'd0;
        res.stamp_us      <= 64'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      total        <= '0;
      rd_cnt       <= '0;
      keep         <= '0;
      sw_cnt       <= '0;
      dv           <= 1'b0;
      found        <= 1'b0;
      window_open  <= 1'b1;
      window_start <= 64'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rd_cnt <= '0;
            keep   <= '0;
            dv     <= 1'b0;
            found  <= 1'b0;
            state  <= ST_AGE;
          end
        end
        ST_AGE: begin
          dv <= rd_en;
          if (rd_en) begin
            rd_cnt <= rd_cnt + CW'(1);
          end
          if (survive) begin
            keep <= keep + CW'(1);
          end
          if (match) begin
            found <= 1'b1;
          end
          if (!rd_en && !dv) begin
            total <= keep;
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sw_cnt <= '0;
          total  <= cnt_after;
          if (found) begin
            window_open <= win_next;
            if (restart) begin
              window_start <= cur_now;
            end
            state <= rise ? ST_SWEEP : ST_DONE;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SWEEP: begin
          if (sw_cnt < total) begin
            sw_cnt <= sw_cnt + CW'(1);
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SMTA_NEVER(a_total_cap, clk, rst, 32'(total) > MAX_MEMBERS, "member total above capacity")
  `SMTA_NEVER(a_idle_quiet, clk, rst, (state == ST_IDLE) && (wa_en || wb_en), "memory write while idle")
  `SMTA_NEVER(a_keep_behind, clk, rst, (state == ST_AGE) && (keep > rd_cnt), "compaction write ahead of read")
  `SMTA_ASSERT(a_start_age, clk, rst, ((state == ST_IDLE) && start) |=> (state == ST_AGE), "accepted word did not start the aging pass")

endmodule

[rtl/session_member_table_with_aging_core.sv]
`timescale 1ns / 1ps
// session member table with aging: config registers, input handshake, output register
// depends on smta_pkg and smta_engine
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------------------
// in       | to core   | in_valid/in_stall  | client_id, now_us, echo_us
// out      | from core | out_valid/out_stall| status, position, latency_valid, latency_us,
//          |           |                    | stamp_us, member_count
// cfg      | to core   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a word runs the aging pass over the N members before aging, then the update step, and
// when the ping window opens, a pending sweep over the N' members left; the member memory
// has one read port and one write port, so aging reads and compaction writes overlap.
// a new word is accepted once the previous one has reached the output register.
// reset is synchronous: table empty, ping window open, registers at their defaults.
// out_stall holds the output register; the engine waits in its done state meanwhile.
module session_member_table_with_aging_core #(
  parameter int MAX_MEMBERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] client_id,
  input  logic [63:0] now_us,
  input  logic [63:0] echo_us,
  // result word channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  position,
  output logic        latency_valid,
  output logic [17:0] latency_us,
  output logic [63:0] stamp_us,
  output logic [4:0]  member_count,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic           idle;
  logic           start;
  logic           res_valid;
  logic           res_take;
  smta_pkg::res_t res;
  logic [4:0]     room_size;
  logic [31:0]    expiry_us;

  // config writes are to be issued only while idle; the core does not enforce this and is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      room_size <= smta_pkg::ROOM_SIZE_RESET;
      expiry_us <= smta_pkg::EXPIRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smta_pkg::CFG_ROOM_SIZE: room_size <= cfg_data[4:0];
        smta_pkg::CFG_EXPIRY:    expiry_us <= cfg_data;
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  // one word in flight in the engine at a time
  assign in_stall = !idle;
  assign start    = in_valid && !in_stall;

  smta_engine #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .client_id (client_id),
    .now_us    (now_us),
    .echo_us   (echo_us),
    .room_size (room_size),
    .expiry_us (expiry_us),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status        <= res.status;
      position      <= res.position;
      latency_valid <= res.latency_valid;
      latency_us    <= res.latency_us;
      stamp_us      <= res.stamp_us;
      member_count  <= res.member_count;
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for session_member_table_with_aging_core: member table with aging
// depends on smta_pkg and the core rtl; predicts every reply word and checks it field by field
module tb_top;

  localparam int MEMBER_SLOTS = 16;
  // receiver hold-off: starts once HOLD_AFTER words went in, HOLD_CYCLES sets its length
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  // idle chance per cycle, in percent, on either side
  localparam int IDLE_PCT     = 21;

  typedef struct {
    logic [31:0] id;
    logic [63:0] now;
    logic [63:0] echo;
  } packet_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] client_id = '0;
  logic [63:0] now_us = '0;
  logic [63:0] echo_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [3:0]  position;
  logic        latency_valid;
  logic [17:0] latency_us;
  logic [63:0] stamp_us;
  logic [4:0]  member_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // packets waiting to be offered, and the reply words they are predicted to give
  packet_t        arrivals_q[$];
  smta_pkg::res_t replies_q[$];
  packet_t        next_pkt;
  smta_pkg::res_t want;

  // shadow of the member table and its registers
  logic [31:0] mem_id      [MEMBER_SLOTS];
  logic [63:0] mem_seen    [MEMBER_SLOTS];
  logic        mem_pending [MEMBER_SLOTS];
  int          member_total = 0;
  logic        win_open = 1'b1;
  logic [63:0] win_start = '0;
  logic [4:0]  room_cfg = smta_pkg::ROOM_SIZE_RESET;
  logic [31:0] expiry_cfg = smta_pkg::EXPIRY_RESET;

  // stimulus and pacing state
  logic [63:0] gen_now = '0;
  bit          steady = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          words_in = 0;
  int          mismatches = 0;
  int          n_known = 0;
  int          n_added = 0;
  int          n_refused = 0;
  int          n_latency = 0;
  int          n_stamped = 0;
  int          n_writes = 0;

  session_member_table_with_aging_core #(.MAX_MEMBERS(MEMBER_SLOTS)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .client_id(client_id),
    .now_us(now_us),
    .echo_us(echo_us),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .position(position),
    .latency_valid(latency_valid),
    .latency_us(latency_us),
    .stamp_us(stamp_us),
    .member_count(member_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ages the table, looks up the client and returns the reply word it should produce
  function automatic smta_pkg::res_t update_member_table(input logic [31:0] id,
                                                         input logic [63:0] now,
                                                         input logic [63:0] echo);
    smta_pkg::res_t r;
    int             keep;
    int             slot;
    int             limit;
    logic [63:0]    gap;
    r = '0;
    r.status = smta_pkg::STATUS_FULL;
    // drop stale members, compacting in order (differences wrap at 64 bits)
    keep = 0;
    for (int k = 0; k < member_total; k++) begin
      gap = now - mem_seen[k];
      if (gap > {32'd0, expiry_cfg}) continue;
      mem_id[keep]      = mem_id[k];
      mem_seen[keep]    = mem_seen[k];
      mem_pending[keep] = mem_pending[k];
      keep++;
    end
    member_total = keep;
    slot = -1;
    for (int k = 0; k < member_total; k++)
      if (slot < 0 && mem_id[k] == id) slot = k;
    if (slot >= 0) begin
      // pending ping with an echo: sample only when under the latency limit, clear anyway
      if (mem_pending[slot] && echo != '0) begin
        gap = now - echo;
        if (gap < smta_pkg::LATENCY_LIMIT_US) begin
          r.latency_valid = 1'b1;
          r.latency_us    = gap[17:0];
        end
        mem_pending[slot] = 1'b0;
      end
      mem_seen[slot] = now;
      r.status   = smta_pkg::STATUS_KNOWN;
      r.position = 4'(slot);
      // ping window, run only for a known member; exactly at the open limit it holds
      gap = now - win_start;
      if (gap < smta_pkg::WINDOW_OPEN_US) begin
        if (!win_open)
          for (int k = 0; k < member_total; k++) mem_pending[k] = 1'b1;
        win_open = 1'b1;
      end
      if (gap > smta_pkg::WINDOW_OPEN_US) win_open = 1'b0;
      if (gap > smta_pkg::WINDOW_PERIOD_US) win_start = now;
      r.stamp_us = win_open ? now : '0;
    end else begin
      // room is capped at the table depth
      limit = (room_cfg < MEMBER_SLOTS) ? int'(room_cfg) : MEMBER_SLOTS;
      if (member_total < limit) begin
        mem_id[member_total]      = id;
        mem_seen[member_total]    = now;
        mem_pending[member_total] = 1'b0;
        member_total++;
        r.status = smta_pkg::STATUS_ADDED;
      end
    end
    r.member_count = 5'(member_total);
    return r;
  endfunction

  // input side: a word moves when valid is high and stall is low; payload holds while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_q = {replies_q, update_member_table(client_id, now_us, echo_us)};
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (arrivals_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_pkt = arrivals_q.pop_front();
          in_valid  <= 1'b1;
          client_id <= next_pkt.id;
          now_us    <= next_pkt.now;
          echo_us   <= next_pkt.echo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side stall: random, off in the steady phase, one long hold to back the core up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && words_in >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // reply checker: every accepted word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (replies_q.size() == 0) begin
        $error("reply word with none predicted: status %0d count %0d", status, member_count);
        mismatches++;
      end else begin
        want = replies_q.pop_front();
        if (status !== want.status) begin
          $error("status expected %0d got %0d", want.status, status);
          mismatches++;
        end
        if (position !== want.position) begin
          $error("position expected %0d got %0d", want.position, position);
          mismatches++;
        end
        if (latency_valid !== want.latency_valid) begin
          $error("latency_valid expected %0d got %0d", want.latency_valid, latency_valid);
          mismatches++;
        end
        if (latency_us !== want.latency_us) begin
          $error("latency_us expected %0d got %0d", want.latency_us, latency_us);
          mismatches++;
        end
        if (stamp_us !== want.stamp_us) begin
          $error("stamp_us expected %h got %h", want.stamp_us, stamp_us);
          mismatches++;
        end
        if (member_count !== want.member_count) begin
          $error("member_count expected %0d got %0d", want.member_count, member_count);
          mismatches++;
        end
        case (want.status)
          smta_pkg::STATUS_KNOWN: n_known++;
          smta_pkg::STATUS_ADDED: n_added++;
          default:                n_refused++;
        endcase
        if (want.latency_valid) n_latency++;
        if (want.stamp_us != '0) n_stamped++;
      end
    end
  end

  task automatic push_packet(input logic [31:0] id, input logic [63:0] now,
                             input logic [63:0] echo);
    packet_t p;
    p.id   = id;
    p.now  = now;
    p.echo = echo;
    arrivals_q = {arrivals_q, p};
  endtask

  // register write while the core is idle; shadow copy follows on the accepting edge
  task automatic write_register(input logic [7:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == smta_pkg::CFG_ROOM_SIZE) room_cfg = val[4:0];
    else if (idx == smta_pkg::CFG_EXPIRY) expiry_cfg = val;
    n_writes++;
  endtask

  // wait for every packet to go in and every reply to come back, then let the core settle
  task automatic settle;
    while (arrivals_q.size() != 0 || in_valid || replies_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // mostly small forward steps over a pool of clients, with jumps, reversals and wraparound
  task automatic queue_random_packets(input int count, input int pool_size);
    logic [31:0] pool [32];
    packet_t     p;
    int          pick;
    for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2)       gen_now = gen_now - $urandom_range(1, 200000);
      else if (pick < 3)  gen_now = {$urandom, $urandom};
      else if (pick < 4)  gen_now = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40000);
      else if (pick < 14) gen_now = gen_now + $urandom_range(0, 2);
      else                gen_now = gen_now + $urandom_range(0, 15000);
      p.now = gen_now;
      p.id  = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
                                           : $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 35)      p.echo = '0;
      else if (pick < 80) p.echo = gen_now - $urandom_range(0, 260000);
      else if (pick < 90) p.echo = {$urandom, $urandom};
      else                p.echo = gen_now + $urandom_range(1, 1000);
      arrivals_q = {arrivals_q, p};
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: reset registers, window edges, latency filter, aging, wraparound
    push_packet(32'd0, 64'd0, 64'd0);                                  // first add
    push_packet(32'hFFFF_FFFF, 64'd5, 64'hFFFF_FFFF_FFFF_FFFF);        // add, echo ignored
    push_packet(32'd0, 64'd100, 64'd0);                                // known, window open
    push_packet(32'd0, 64'd10000, 64'd0);                              // right at open limit
    push_packet(32'd0, 64'd10001, 64'd0);                              // window closes
    push_packet(32'hFFFF_FFFF, 64'd100001, 64'd0);                     // period restarts
    push_packet(32'd0, 64'd100002, 64'd50);                            // rising edge
    push_packet(32'hFFFF_FFFF, 64'd300000, 64'd100001);                // sample just under
    push_packet(32'd0, 64'd300001, 64'd100001);                        // at limit: dropped
    push_packet(32'd0, 64'd300002, 64'd300003);                        // echo in the future
    push_packet(32'hFFFF_FFFF, 64'd300003, 64'd0);                     // no echo, stays pending
    push_packet(32'hFFFF_FFFF, 64'd300004, 64'd300004);                // zero round trip
    push_packet(32'd7, 64'd1300005, 64'd0);                            // both expire
    push_packet(32'd8, 64'd2300005, 64'd0);                            // exactly at expiry: kept
    push_packet(32'd7, 64'd2300005, 64'd0);                            // known after the limit
    push_packet(32'd9, 64'd5, 64'd0);                                  // time runs backwards
    push_packet(32'd9, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    push_packet(32'd9, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    push_packet(32'h5555_5555, 64'd3, 64'hFFFF_FFFF_FFFF_FFFF);        // clock wraps
    push_packet(32'd9, 64'd4, 64'hFFFF_FFFF_FFFF_FFFF);                // edge across the wrap
    push_packet(32'h5555_5555, 64'd6, 64'hFFFF_FFFF_FFFF_FFFF);        // sample across the wrap
    push_packet(32'hAAAA_AAAA, 64'd7, 64'd0);
    gen_now = 64'd7;
    settle();

    // full room, default expiry, no idling on either side
    write_register(smta_pkg::CFG_ROOM_SIZE, 32'd16);
    write_register(smta_pkg::CFG_EXPIRY, 32'd1000000);
    steady = 1'b1;
    queue_random_packets(280, 20);
    settle();
    steady = 1'b0;

    // small room, short expiry; the long receiver hold falls in here
    write_register(smta_pkg::CFG_ROOM_SIZE, 32'd4);
    write_register(smta_pkg::CFG_EXPIRY, 32'd50000);
    queue_random_packets(280, 6);
    settle();

    // room above the table depth, longest expiry, a write to an unused index
    write_register(smta_pkg::CFG_ROOM_SIZE, 32'd31);
    write_register(smta_pkg::CFG_EXPIRY, 32'hFFFF_FFFF);
    write_register(8'hFF, 32'hFFFF_FFFF);
    queue_random_packets(300, 24);
    settle();

    // no room at all, shortest expiry
    write_register(smta_pkg::CFG_ROOM_SIZE, 32'd0);
    write_register(smta_pkg::CFG_EXPIRY, 32'd1);
    queue_random_packets(120, 4);
    settle();

    // single seat
    write_register(smta_pkg::CFG_ROOM_SIZE, 32'd1);
    write_register(smta_pkg::CFG_EXPIRY, 32'd20000);
    queue_random_packets(300, 3);
    settle();

    write_register(smta_pkg::CFG_ROOM_SIZE, 32'd12);
    write_register(smta_pkg::CFG_EXPIRY, 32'd300000);
    queue_random_packets(380, 16);
    settle();

    $display("ran %0d packets: %0d refreshed members, %0d joins, %0d refusals",
             words_in, n_known, n_added, n_refused);
    $display("saw %0d round-trip samples, %0d window stamps, %0d register writes",
             n_latency, n_stamped, n_writes);
    if (mismatches == 0 && replies_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/smta_pkg.sv
rtl/smta_engine.sv
rtl/session_member_table_with_aging_core.sv
bench/tb_top.sv
